// ===== rtl/utf8_byte_sanitizer_top_defines.svh =====
// ----------------------------------------------------------------------------
// UTF-8 byte sanitiser assertion macros
// Shared property macros for the checker attached to the sanitiser.
// ----------------------------------------------------------------------------
`ifndef UTF8_BYTE_SANITIZER_TOP_DEFINES_SVH
`define UTF8_BYTE_SANITIZER_TOP_DEFINES_SVH

// Property checked outside reset
`define U8SAN_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included
`define U8SAN_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/u8san_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 byte sanitiser package
// Widths, constants and decode helpers shared by the sanitiser files.
// ----------------------------------------------------------------------------
package u8san_pkg;

   localparam int BYTE_WIDTH = 8;
   // Longest burst from one transaction: four replacement sequences
   localparam int MAX_BYTES  = 12;
   localparam int CNT_WIDTH  = $clog2(MAX_BYTES + 1);
   localparam int HELD_DEPTH = 3;

   localparam logic [BYTE_WIDTH-1:0] REPL_BYTE0 = 8'hEF;
   localparam logic [BYTE_WIDTH-1:0] REPL_BYTE1 = 8'hBF;
   localparam logic [BYTE_WIDTH-1:0] REPL_BYTE2 = 8'hBD;

   typedef logic [BYTE_WIDTH-1:0] byte_type;
   typedef logic [CNT_WIDTH-1:0]  count_type;

   // Byte k of U+FFFD in UTF-8
   function automatic byte_type repl_byte(input logic [1:0] k);
      byte_type b;
      case (k)
         2'd0:    b = REPL_BYTE0;
         2'd1:    b = REPL_BYTE1;
         default: b = REPL_BYTE2;
      endcase
      return b;
   endfunction

   // Sequence length opened by a lead byte; zero if not a lead
   function automatic logic [2:0] lead_length(input byte_type b);
      logic [2:0] len;
      if ((b & 8'hE0) == 8'hC0) begin
         len = 3'd2;
      end else if ((b & 8'hF0) == 8'hE0) begin
         len = 3'd3;
      end else if ((b & 8'hF8) == 8'hF0) begin
         len = 3'd4;
      end else begin
         len = 3'd0;
      end
      return len;
   endfunction

   function automatic logic is_continuation(input byte_type b);
      return (b & 8'hC0) == 8'h80;
   endfunction

endpackage

// ===== rtl/utf8_byte_sanitizer_top.sv =====
// ----------------------------------------------------------------------------
// UTF-8 byte sanitiser
// Streams UTF-8 text byte by byte and replaces malformed bytes with U+FFFD.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one input byte per transaction, req_tlast on the final byte
//   of a string. rsp_* carries the repaired text one byte per transaction,
//   rsp_tlast on the final output byte of the string.
//   ASCII bytes pass straight through. A lead byte and its continuation bytes
//   are held until the sequence completes, then sent together. Any malformed
//   byte, or held bytes cut short, become EF BF BD each.
// Output: the first output byte is registered and appears in the cycle after its input is taken.
// Throughput: one byte per cycle on both sides for ASCII text while rsp_tready is high. An
//   input that yields N output bytes holds req_tready low while the output buffer drains,
//   one byte per cycle while rsp_tready is high; N is at most 12.
// Reset: clears the held sequence and empties the output buffer.
// Stall: while a byte is on show and rsp_tready is low, that byte holds and req_tready stays
//   low, so no input is taken until the pending bytes have gone out.
// ----------------------------------------------------------------------------
module utf8_byte_sanitizer_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [u8san_pkg::BYTE_WIDTH-1:0] req_tdata,  // [7:0] in_byte
   input  logic                           req_tlast,    // in_last
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [u8san_pkg::BYTE_WIDTH-1:0] rsp_tdata,  // [7:0] out_byte
   output logic                           rsp_tlast     // out_last
);

   localparam int NB = u8san_pkg::MAX_BYTES;
   localparam int ND = u8san_pkg::HELD_DEPTH;

   // Sequence state
   u8san_pkg::byte_type  held_ff [ND];
   logic [1:0]           hc_ff, hc_in;
   logic [2:0]           len_ff, len_in;

   // Output buffer
   u8san_pkg::byte_type  obuf_ff [NB];
   u8san_pkg::byte_type  obuf_in [NB];
   u8san_pkg::count_type rem_ff;
   logic                 last_ff;

   // Decode results
   logic                 req_fire, rsp_fire;
   logic                 raw_mode;
   logic                 tail;
   logic [2:0]           nrep;
   logic [2:0]           lead_len;
   logic                 wr_en;
   logic [1:0]           wr_idx;
   u8san_pkg::count_type rep_bytes, count_in;

   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (rem_ff != '0);
   assign rsp_tdata  = obuf_ff[0];
   assign rsp_tlast  = last_ff && (rem_ff == u8san_pkg::count_type'(1));
   assign req_tready = (rem_ff == '0) ||
                       ((rem_ff == u8san_pkg::count_type'(1)) && rsp_tready);
   assign lead_len   = u8san_pkg::lead_length(req_tdata);

   // Classify the incoming byte against the open sequence
   always_comb begin
      raw_mode = 1'b0;
      tail     = 1'b0;
      nrep     = 3'd0;
      hc_in    = hc_ff;
      len_in   = len_ff;
      wr_en    = 1'b0;
      wr_idx   = 2'd0;
      if ((hc_ff != 2'd0) && u8san_pkg::is_continuation(req_tdata)) begin
         if (({1'b0, hc_ff} + 3'd1) >= len_ff) begin
            // sequence complete: send held bytes and this one
            raw_mode = 1'b1;
            hc_in    = 2'd0;
            len_in   = 3'd0;
         end else begin
            wr_en  = 1'b1;
            wr_idx = hc_ff;
            hc_in  = hc_ff + 2'd1;
            if (req_tlast) begin
               // string ends inside the sequence
               nrep   = {1'b0, hc_ff} + 3'd1;
               hc_in  = 2'd0;
               len_in = 3'd0;
            end
         end
      end else begin
         // flush anything held, then treat the byte afresh
         nrep   = {1'b0, hc_ff};
         hc_in  = 2'd0;
         len_in = 3'd0;
         if (req_tdata < 8'h80) begin
            tail = 1'b1;
         end else if (lead_len != 3'd0) begin
            if (req_tlast) begin
               nrep = nrep + 3'd1;
            end else begin
               wr_en  = 1'b1;
               wr_idx = 2'd0;
               hc_in  = 2'd1;
               len_in = lead_len;
            end
         end else begin
            nrep = nrep + 3'd1;
         end
      end
   end

   // Lay out the output bytes of this transaction
   always_comb begin
      rep_bytes = u8san_pkg::count_type'({nrep, 1'b0}) + u8san_pkg::count_type'(nrep);
      count_in  = raw_mode ? u8san_pkg::count_type'({1'b0, hc_ff}) + u8san_pkg::count_type'(1)
                           : rep_bytes + u8san_pkg::count_type'(tail);
      for (int i = 0; i < NB; i++) begin
         obuf_in[i] = '0;
         if (raw_mode) begin
            if ((i < ND) && (u8san_pkg::count_type'(i) < u8san_pkg::count_type'(hc_ff))) begin
               obuf_in[i] = held_ff[(i < ND) ? i : 0];
            end else if (u8san_pkg::count_type'(i) == u8san_pkg::count_type'(hc_ff)) begin
               obuf_in[i] = req_tdata;
            end
         end else begin
            if (u8san_pkg::count_type'(i) < rep_bytes) begin
               obuf_in[i] = u8san_pkg::repl_byte(2'(i % 3));
            end else if (tail && (u8san_pkg::count_type'(i) == rep_bytes)) begin
               obuf_in[i] = req_tdata;
            end
         end
      end
   end

   // Sequence state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hc_ff  <= 2'd0;
         len_ff <= 3'd0;
      end else if (req_fire) begin
         hc_ff  <= hc_in;
         len_ff <= len_in;
      end
   end

   // Held byte store
   always_ff @(posedge clock) begin
      if (req_fire && wr_en) begin
         held_ff[wr_idx] <= req_tdata;
      end
   end

   // Output buffer: load on every accepted input byte, shift as the bytes go
   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else if (req_fire) begin
         rem_ff <= count_in;
      end else if (rsp_fire) begin
         rem_ff <= rem_ff - u8san_pkg::count_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         obuf_ff <= obuf_in;
         last_ff <= req_tlast;
      end else if (rsp_fire) begin
         for (int k = 0; k < NB - 1; k++) begin
            obuf_ff[k] <= obuf_ff[k+1];
         end
      end
   end

endmodule

// ===== rtl/u8san_checker.sv =====
// ----------------------------------------------------------------------------
// UTF-8 byte sanitiser checker
// Port-level assertions on the sanitiser, attached by bind.
// ----------------------------------------------------------------------------
`include "utf8_byte_sanitizer_top_defines.svh"

module u8san_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [u8san_pkg::BYTE_WIDTH-1:0] req_tdata,
   input  logic                             req_tlast,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [u8san_pkg::BYTE_WIDTH-1:0] rsp_tdata,
   input  logic                             rsp_tlast
);

   // Buffer is empty straight after reset
   `U8SAN_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "output valid after reset")

   // A stalled output byte blocks new input
   `U8SAN_ASSERT(a_stall_blocks, clock, reset, (rsp_tvalid && !rsp_tready) |-> !req_tready, "input taken while output stalled")

   // Stalled output transaction holds steady
   `U8SAN_ASSERT(a_stall_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)), "stalled output changed")

   // A final input byte always yields output next cycle
   `U8SAN_ASSERT(a_last_output, clock, reset, (req_tvalid && req_tready && req_tlast) |=> rsp_tvalid, "no output after final byte")

endmodule

bind utf8_byte_sanitizer_top u8san_checker u_u8san_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
